// ===== design/amou_pkg.sv =====
// ----------------------------------------------------------------------------
// amou_pkg
// Shared types and constants of the atomic memory operation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package amou_pkg;

	localparam logic [3:0] CMD_LOAD     = 4'd0;
	localparam logic [3:0] CMD_STORE    = 4'd1;
	localparam logic [3:0] CMD_ADD      = 4'd2;
	localparam logic [3:0] CMD_SUB      = 4'd3;
	localparam logic [3:0] CMD_AND      = 4'd4;
	localparam logic [3:0] CMD_OR       = 4'd5;
	localparam logic [3:0] CMD_XOR      = 4'd6;
	localparam logic [3:0] CMD_EXCHANGE = 4'd7;
	localparam logic [3:0] CMD_CMPXCHG  = 4'd8;
	localparam logic [3:0] CMD_TEST     = 4'd9;

	localparam logic REG_ELEMENT_WIDTH = 1'b0;
	localparam logic REG_VIEW_LENGTH   = 1'b1;

	typedef struct packed {
		logic clear_en;
		logic accept;
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== design/amou_ram.sv =====
// ----------------------------------------------------------------------------
// amou_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module amou_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/amou_ctrl.sv =====
// ----------------------------------------------------------------------------
// amou_ctrl
// Controller: clearing pass after reset, transaction accept and execute.
// ----------------------------------------------------------------------------
`default_nettype none

module amou_ctrl
	import amou_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd,
	output logic           busy,
	output logic           done
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	always_comb begin
		cmd.clear_en = (state_q == ST_CLEAR);
		cmd.accept   = (state_q == ST_IDLE) && start;
		cmd.exec     = (state_q == ST_EXEC);
		state_d      = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

// ===== design/amou_datapath.sv =====
// ----------------------------------------------------------------------------
// amou_datapath
// Datapath: configuration, range check, two-bank word memory and the
// read-modify-write operation.
// ----------------------------------------------------------------------------
`default_nettype none

module amou_datapath
	import amou_pkg::*;
#(
	parameter int MEMORY_WORDS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctrl_cmd_t          cmd,
	output ctrl_sts_t               sts,
	input  wire logic               cfg_write_en,
	input  wire logic               cfg_index,
	input  wire logic [10:0]        cfg_data,
	input  wire logic [3:0]         command,
	input  wire logic signed [11:0] element_index,
	input  wire logic signed [63:0] operand_value,
	input  wire logic signed [63:0] expected_value,
	output logic signed [63:0]      result_value,
	output logic                    out_of_range
);

	localparam int ROWS = (MEMORY_WORDS + 1) / 2;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [16:0] MEM_WORDS_W = 17'(MEMORY_WORDS);
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	logic        element_width_q;
	logic [10:0] view_length_q;

	logic [12:0] word_w;
	logic [12:0] top_w;
	logic [15:0] row_full;
	logic [RW-1:0] rd_row;
	logic        oor_in;

	logic [3:0]    cmd_q;
	logic          oor_q;
	logic          bank_q;
	logic          wide_q;
	logic [RW-1:0] row_q;
	logic [63:0]   opv_q;
	logic [63:0]   expv_q;
	logic [RW-1:0] clr_cnt_q;

	logic [31:0] even_rd;
	logic [31:0] odd_rd;
	logic        even_we;
	logic        odd_we;
	logic [RW-1:0] wr_row;
	logic [31:0] even_wd;
	logic [31:0] odd_wd;

	logic [63:0] old_v;
	logic [63:0] opm;
	logic [63:0] expm;
	logic [63:0] new_v;
	logic [63:0] res_v;
	logic        res_oor;
	logic        eq;
	logic        wr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_width_q <= 1'b0;
			view_length_q   <= 11'd0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_ELEMENT_WIDTH: element_width_q <= cfg_data[0];
				REG_VIEW_LENGTH:   view_length_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		word_w   = element_width_q ? {element_index, 1'b0} : {1'b0, element_index};
		top_w    = element_width_q ? word_w + 13'd1 : word_w;
		oor_in   = element_index[11] || (element_index[10:0] >= view_length_q)
			|| ({4'd0, top_w} >= MEM_WORDS_W);
		row_full = {4'd0, word_w[12:1]};
		rd_row   = row_full[RW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= command;
			oor_q  <= oor_in;
			bank_q <= element_index[0];
			wide_q <= element_width_q;
			row_q  <= rd_row;
			opv_q  <= operand_value;
			expv_q <= expected_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_en) begin
			clr_cnt_q <= (clr_cnt_q == LAST_ROW) ? '0 : clr_cnt_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_cnt_q == LAST_ROW);

	always_comb begin
		old_v = wide_q ? {odd_rd, even_rd} : {32'd0, bank_q ? odd_rd : even_rd};
		opm   = wide_q ? opv_q : {32'd0, opv_q[31:0]};
		expm  = wide_q ? expv_q : {32'd0, expv_q[31:0]};
		eq    = (old_v == expm);
		case (cmd_q)
			CMD_STORE:    new_v = opm;
			CMD_ADD:      new_v = old_v + opm;
			CMD_SUB:      new_v = old_v - opm;
			CMD_AND:      new_v = old_v & opm;
			CMD_OR:       new_v = old_v | opm;
			CMD_XOR:      new_v = old_v ^ opm;
			CMD_EXCHANGE: new_v = opm;
			CMD_CMPXCHG:  new_v = eq ? opm : old_v;
			default:      new_v = old_v;
		endcase

		wr_ok = !oor_q && (cmd_q >= CMD_STORE) && (cmd_q <= CMD_CMPXCHG);

		if (cmd_q > CMD_TEST) begin
			res_v   = 64'd0;
			res_oor = 1'b0;
		end else if (oor_q) begin
			res_oor = 1'b1;
			if (cmd_q == CMD_STORE) begin
				res_v = opv_q;
			end else if (cmd_q == CMD_TEST) begin
				res_v = 64'd1;
			end else begin
				res_v = 64'd0;
			end
		end else begin
			res_oor = 1'b0;
			if (cmd_q == CMD_STORE) begin
				res_v = opv_q;
			end else if (cmd_q == CMD_TEST) begin
				res_v = {63'd0, !eq};
			end else if (wide_q) begin
				res_v = old_v;
			end else begin
				res_v = {{32{old_v[31]}}, old_v[31:0]};
			end
		end

		if (cmd.clear_en) begin
			even_we = 1'b1;
			odd_we  = 1'b1;
			wr_row  = clr_cnt_q;
			even_wd = 32'd0;
			odd_wd  = 32'd0;
		end else begin
			even_we = cmd.exec && wr_ok && (wide_q || !bank_q);
			odd_we  = cmd.exec && wr_ok && (wide_q || bank_q);
			wr_row  = row_q;
			even_wd = new_v[31:0];
			odd_wd  = wide_q ? new_v[63:32] : new_v[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_value <= res_v;
			out_of_range <= res_oor;
		end
	end

	amou_ram #(
		.WIDTH(32),
		.DEPTH(ROWS)
	) u_even_ram (
		.clk   (clk),
		.we    (even_we),
		.waddr (wr_row),
		.wdata (even_wd),
		.re    (cmd.accept),
		.raddr (rd_row),
		.rdata (even_rd)
	);

	amou_ram #(
		.WIDTH(32),
		.DEPTH(ROWS)
	) u_odd_ram (
		.clk   (clk),
		.we    (odd_we),
		.waddr (wr_row),
		.wdata (odd_wd),
		.re    (cmd.accept),
		.raddr (rd_row),
		.rdata (odd_rd)
	);

endmodule

`default_nettype wire

// ===== design/atomic_memory_op_unit_top.sv =====
// ----------------------------------------------------------------------------
// atomic_memory_op_unit_top
// Atomic read-modify-write unit over a zero-cleared 32-bit word memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low: the element is
// read from two word banks (even and odd words, so a 64-bit pair comes out
// in one registered read), then modified and written back while the result
// is registered. done is high for one cycle with result_value and
// out_of_range; results cannot be held off, so capture them on that cycle.
// A new transaction may start in the cycle done is shown. After reset busy
// stays high while the memory is cleared one row a cycle; configuration
// writes are taken during that time.
`default_nettype none

module atomic_memory_op_unit_top
	import amou_pkg::*;
#(
	parameter int MEMORY_WORDS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [3:0]         command,
	input  wire logic signed [11:0] element_index,
	input  wire logic signed [63:0] operand_value,
	input  wire logic signed [63:0] expected_value,
	output logic                    done,
	output logic signed [63:0]      result_value,
	output logic                    out_of_range,
	input  wire logic               cfg_write_en,
	input  wire logic               cfg_index,
	input  wire logic [10:0]        cfg_data
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	amou_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	amou_datapath #(
		.MEMORY_WORDS(MEMORY_WORDS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.command        (command),
		.element_index  (element_index),
		.operand_value  (operand_value),
		.expected_value (expected_value),
		.result_value   (result_value),
		.out_of_range   (out_of_range)
	);

endmodule

`default_nettype wire

// ===== design/amou_checker.sv =====
// ----------------------------------------------------------------------------
// amou_port_checks
// Port-level checks of transaction timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module amou_port_checks (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low in the cycle after a transaction was taken");

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("no result two cycles after a transaction was taken");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && $past(start && !busy, 2)))
		else $error("result without a matching transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high for two cycles");

endmodule

bind atomic_memory_op_unit_top amou_port_checks u_amou_port_checks (.*);

`default_nettype wire
